>>> rtl/scsf_pkg.sv
// ----------------------------------------------------------------------------
// Session filter package
// Command codes, action codes and reset values shared by the session filter.
// ----------------------------------------------------------------------------
package scsf_pkg;

  typedef logic [2:0] action_t;

  localparam action_t ACT_NONE    = 3'd0;
  localparam action_t ACT_BUSY    = 3'd1;
  localparam action_t ACT_RESEND  = 3'd2;
  localparam action_t ACT_NEW     = 3'd3;
  localparam action_t ACT_EXEC    = 3'd4;
  localparam action_t ACT_UNKNOWN = 3'd5;

  localparam logic [7:0] CMD_CONNECT   = 8'h80;
  localparam logic [7:0] CMD_KNOWN_MAX = 8'h85;

  localparam logic [7:0] KEEPALIVE_RESET = 8'd90;

  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_TICK  = 1'b1;

endpackage

>>> rtl/scsf_if.sv
// ----------------------------------------------------------------------------
// Session filter channels
// Valid/ready channels for requests, results and the keepalive register.
// ----------------------------------------------------------------------------
interface scsf_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [15:0] src_addr;
  logic [7:0]  seqnum;
  logic [7:0]  command;

  modport source (output valid, output op, output src_addr, output seqnum,
                  output command, input ready);
  modport sink (input valid, input op, input src_addr, input seqnum,
                input command, output ready);
endinterface

interface scsf_out_if;
  logic                  valid;
  logic                  ready;
  scsf_pkg::action_t     action;
  logic                  link_up;
  logic [15:0]           client_addr;

  modport source (output valid, output action, output link_up, output client_addr,
                  input ready);
  modport sink (input valid, input action, input link_up, input client_addr,
                output ready);
endinterface

interface scsf_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] keepalive_ticks;

  modport source (output valid, output keepalive_ticks, input ready);
  modport sink (input valid, input keepalive_ticks, output ready);
endinterface

>>> rtl/single_client_session_filter.sv
// A request is captured in the input register and its result in the result register.
// Throughput: one request per cycle; the input register and the result register
// advance together whenever the result register is empty or being taken.
// Reset: synchronous, active low; it clears the session, both registers' valid
// bits and loads the keepalive register with 90.
// ----------------------------------------------------------------------------
// Single client session filter
// Admits frames from one client, tracks its keepalive and reports an action.
// ----------------------------------------------------------------------------
module single_client_session_filter (
  input logic         clk,
  input logic         rst_n,
  scsf_in_if.sink     in_if,
  scsf_out_if.source  out_if,
  scsf_cfg_if.sink    cfg_if
);

  logic [7:0]  keepalive_r;

  logic        in_v_r;
  logic        op_r;
  logic [15:0] sender_r;
  logic [7:0]  seq_r;
  logic [7:0]  cmd_r;

  logic        held_r, held_nxt;
  logic [15:0] holder_r, holder_nxt;
  logic [7:0]  alive_r, alive_nxt;
  logic [7:0]  last_seq_r, last_seq_nxt;

  logic              out_v_r;
  scsf_pkg::action_t action_r, action_nxt;
  logic              link_r;
  logic [15:0]       client_r;

  logic advance;
  logic is_connect;
  logic is_holder;

  assign cfg_if.ready = 1'b1;

  assign advance     = !out_v_r || out_if.ready;
  assign in_if.ready = !in_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keepalive_r <= scsf_pkg::KEEPALIVE_RESET;
    end else if (cfg_if.valid && cfg_if.ready) begin
      keepalive_r <= cfg_if.keepalive_ticks;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_if.ready) begin
      in_v_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      op_r     <= in_if.op;
      sender_r <= in_if.src_addr;
      seq_r    <= in_if.seqnum;
      cmd_r    <= in_if.command;
    end
  end

  assign is_connect = (cmd_r == scsf_pkg::CMD_CONNECT);
  assign is_holder  = held_r && (holder_r == sender_r);

  always_comb begin
    held_nxt     = held_r;
    holder_nxt   = holder_r;
    alive_nxt    = alive_r;
    last_seq_nxt = last_seq_r;
    action_nxt   = scsf_pkg::ACT_NONE;
    if (op_r == scsf_pkg::OP_TICK) begin
      if (held_r) begin
        if (alive_r == 8'd0) begin
          held_nxt = 1'b0;
        end else begin
          alive_nxt = alive_r - 8'd1;
        end
      end
    end else if (is_connect) begin
      if (held_r && !is_holder) begin
        action_nxt = scsf_pkg::ACT_BUSY;
      end else begin
        held_nxt     = 1'b1;
        holder_nxt   = sender_r;
        alive_nxt    = keepalive_r;
        last_seq_nxt = seq_r;
        action_nxt   = scsf_pkg::ACT_NEW;
      end
    end else if (is_holder) begin
      alive_nxt = keepalive_r;
      if (seq_r == last_seq_r) begin
        action_nxt = scsf_pkg::ACT_RESEND;
      end else begin
        last_seq_nxt = seq_r;
        if (cmd_r > scsf_pkg::CMD_CONNECT && cmd_r <= scsf_pkg::CMD_KNOWN_MAX) begin
          action_nxt = scsf_pkg::ACT_EXEC;
        end else begin
          action_nxt = scsf_pkg::ACT_UNKNOWN;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r     <= 1'b0;
      holder_r   <= 16'd0;
      alive_r    <= 8'd0;
      last_seq_r <= 8'd0;
      out_v_r    <= 1'b0;
    end else if (advance) begin
      out_v_r <= in_v_r;
      if (in_v_r) begin
        held_r     <= held_nxt;
        holder_r   <= holder_nxt;
        alive_r    <= alive_nxt;
        last_seq_r <= last_seq_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_v_r) begin
      action_r <= action_nxt;
      link_r   <= held_nxt;
      client_r <= held_nxt ? holder_nxt : 16'd0;
    end
  end

  assign out_if.valid       = out_v_r;
  assign out_if.action      = action_r;
  assign out_if.link_up     = link_r;
  assign out_if.client_addr = client_r;

`ifndef ASSERT_OFF
  a_busy_needs_link: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && action_r == scsf_pkg::ACT_BUSY |-> link_r)
    else $error("busy result without a held session");

  a_new_sets_link: assert property (@(posedge clk) disable iff (!rst_n)
    $past(advance && in_v_r) && out_v_r &&
      (action_r == scsf_pkg::ACT_NEW || action_r == scsf_pkg::ACT_RESEND)
      |-> link_r && client_r == $past(sender_r))
    else $error("accepted frame does not report its sender as holder");

  a_down_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !link_r |-> client_r == 16'd0)
    else $error("client address reported without a session");

  a_drop_only_by_tick: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $fell(held_r) |-> $past(in_v_r && advance && op_r == scsf_pkg::OP_TICK))
    else $error("session dropped by something other than a tick");
`endif

endmodule

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// Session filter testbench
// Drives frames and timer ticks into the session filter under several
// keepalive settings and idling patterns, predicts each action and link
// state in a model of its own, and compares every result field by field.
// ----------------------------------------------------------------------------
module tb;
  import scsf_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_CYCLES = 60;
  localparam int NUM_ROWS = 27;

  typedef struct packed {
    action_t     action;
    logic        link_up;
    logic [15:0] client_addr;
  } link_result_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic        op;
    logic [15:0] addr;
    logic [7:0]  seq;
    logic [7:0]  cmd;
    logic [7:0]  ka;
    logic        typed;
    action_t     action;
    logic        link_up;
    logic [15:0] client_addr;
  } plan_row_t;

  logic clk;
  logic rst_n;

  scsf_in_if  in_ch ();
  scsf_out_if out_ch ();
  scsf_cfg_if cfg_ch ();

  single_client_session_filter dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  // Model of the session state and the keepalive register.
  logic        sess_up = 1'b0;
  logic [15:0] holder = 16'h0000;
  logic [7:0]  alive = 8'd0;
  logic [7:0]  last_seq = 8'd0;
  logic [7:0]  ka_ticks = KEEPALIVE_RESET;

  link_result_t pending_results[$];
  int mismatch_count = 0;
  int cycle_count = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  logic hold_go = 1'b0;
  logic hold_off;

  // The directed requests; expected results are typed in only where obvious.
  plan_row_t plan [NUM_ROWS] = '{
    '{ROW_REQ, OP_TICK,  16'h0000, 8'h00, 8'h00, 8'd0, 1'b1, ACT_NONE,    1'b0, 16'h0000},
    '{ROW_REQ, OP_FRAME, 16'h0000, 8'h00, 8'h81, 8'd0, 1'b1, ACT_NONE,    1'b0, 16'h0000},
    '{ROW_REQ, OP_FRAME, 16'hFFFF, 8'h00, 8'h80, 8'd0, 1'b1, ACT_NEW,     1'b1, 16'hFFFF},
    '{ROW_REQ, OP_FRAME, 16'h1234, 8'h05, 8'h81, 8'd0, 1'b1, ACT_NONE,    1'b1, 16'hFFFF},
    '{ROW_REQ, OP_FRAME, 16'h0000, 8'h09, 8'h80, 8'd0, 1'b1, ACT_BUSY,    1'b1, 16'hFFFF},
    '{ROW_REQ, OP_FRAME, 16'hFFFF, 8'h00, 8'h81, 8'd0, 1'b1, ACT_RESEND,  1'b1, 16'hFFFF},
    '{ROW_REQ, OP_FRAME, 16'hFFFF, 8'hFF, 8'h85, 8'd0, 1'b1, ACT_EXEC,    1'b1, 16'hFFFF},
    '{ROW_REQ, OP_FRAME, 16'hFFFF, 8'h01, 8'h86, 8'd0, 1'b1, ACT_UNKNOWN, 1'b1, 16'hFFFF},
    '{ROW_REQ, OP_FRAME, 16'hFFFF, 8'h02, 8'h00, 8'd0, 1'b1, ACT_UNKNOWN, 1'b1, 16'hFFFF},
    '{ROW_REQ, OP_FRAME, 16'hFFFF, 8'h03, 8'hFF, 8'd0, 1'b1, ACT_UNKNOWN, 1'b1, 16'hFFFF},
    '{ROW_REQ, OP_FRAME, 16'hFFFF, 8'h04, 8'h7F, 8'd0, 1'b1, ACT_UNKNOWN, 1'b1, 16'hFFFF},
    '{ROW_REQ, OP_FRAME, 16'hFFFF, 8'h04, 8'h80, 8'd0, 1'b1, ACT_NEW,     1'b1, 16'hFFFF},
    '{ROW_REQ, OP_TICK,  16'hFFFF, 8'hFF, 8'hFF, 8'd0, 1'b1, ACT_NONE,    1'b1, 16'hFFFF},
    '{ROW_CFG, OP_FRAME, 16'h0000, 8'h00, 8'h00, 8'd0, 1'b0, ACT_NONE,    1'b0, 16'h0000},
    '{ROW_REQ, OP_FRAME, 16'hFFFF, 8'h10, 8'h83, 8'd0, 1'b0, ACT_NONE,    1'b0, 16'h0000},
    '{ROW_REQ, OP_TICK,  16'h0000, 8'h00, 8'h00, 8'd0, 1'b0, ACT_NONE,    1'b0, 16'h0000},
    '{ROW_REQ, OP_TICK,  16'h0000, 8'h00, 8'h00, 8'd0, 1'b0, ACT_NONE,    1'b0, 16'h0000},
    '{ROW_REQ, OP_FRAME, 16'h5A5A, 8'h80, 8'h80, 8'd0, 1'b0, ACT_NONE,    1'b0, 16'h0000},
    '{ROW_CFG, OP_FRAME, 16'h0000, 8'h00, 8'h00, 8'd255, 1'b0, ACT_NONE,  1'b0, 16'h0000},
    '{ROW_REQ, OP_FRAME, 16'h5A5A, 8'h80, 8'h81, 8'd0, 1'b0, ACT_NONE,    1'b0, 16'h0000},
    '{ROW_REQ, OP_FRAME, 16'hA5A5, 8'h80, 8'h80, 8'd0, 1'b0, ACT_NONE,    1'b0, 16'h0000},
    '{ROW_CFG, OP_FRAME, 16'h0000, 8'h00, 8'h00, 8'd1, 1'b0, ACT_NONE,    1'b0, 16'h0000},
    '{ROW_REQ, OP_FRAME, 16'h5A5A, 8'h81, 8'h84, 8'd0, 1'b0, ACT_NONE,    1'b0, 16'h0000},
    '{ROW_REQ, OP_TICK,  16'h0000, 8'h00, 8'h00, 8'd0, 1'b0, ACT_NONE,    1'b0, 16'h0000},
    '{ROW_REQ, OP_TICK,  16'h0000, 8'h00, 8'h00, 8'd0, 1'b0, ACT_NONE,    1'b0, 16'h0000},
    '{ROW_REQ, OP_TICK,  16'h0000, 8'h00, 8'h00, 8'd0, 1'b0, ACT_NONE,    1'b0, 16'h0000},
    '{ROW_REQ, OP_FRAME, 16'h5A5A, 8'h82, 8'h82, 8'd0, 1'b0, ACT_NONE,    1'b0, 16'h0000}
  };

  function automatic link_result_t filter_step(logic op, logic [15:0] addr,
                                               logic [7:0] seq, logic [7:0] cmd);
    link_result_t res;
    logic is_conn;
    logic done;
    res.action = ACT_NONE;
    is_conn = (cmd == CMD_CONNECT);
    done = 1'b0;
    if (op == OP_TICK) begin
      if (sess_up) begin
        if (alive == 8'd0) begin
          sess_up = 1'b0;
        end else begin
          alive = alive - 8'd1;
        end
      end
    end else begin
      if (is_conn && sess_up) begin
        if (holder == addr) begin
          sess_up = 1'b0;
        end else begin
          res.action = ACT_BUSY;
          done = 1'b1;
        end
      end
      if (!done && !is_conn && (!sess_up || holder != addr)) begin
        done = 1'b1;
      end
      if (!done && sess_up && seq == last_seq) begin
        alive = ka_ticks;
        res.action = ACT_RESEND;
        done = 1'b1;
      end
      if (!done) begin
        alive = ka_ticks;
        last_seq = seq;
        if (is_conn) begin
          holder = addr;
          sess_up = 1'b1;
          res.action = ACT_NEW;
        end else if (cmd > CMD_CONNECT && cmd <= CMD_KNOWN_MAX) begin
          res.action = ACT_EXEC;
        end else begin
          res.action = ACT_UNKNOWN;
        end
      end
    end
    res.link_up = sess_up;
    res.client_addr = sess_up ? holder : 16'h0000;
    return res;
  endfunction

  function automatic logic [15:0] pick_addr();
    case ($urandom_range(0, 4))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h5A5A;
      3: return 16'hA5A5;
      default: return 16'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  task automatic send_req(input logic op, input logic [15:0] addr, input logic [7:0] seq,
                          input logic [7:0] cmd, input logic typed,
                          input link_result_t typed_res);
    link_result_t res;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.src_addr <= addr;
    in_ch.seqnum <= seq;
    in_ch.command <= cmd;
    do @(posedge clk); while (!in_ch.ready);
    res = filter_step(op, addr, seq, cmd);
    pending_results.push_back(typed ? typed_res : res);
  endtask

  task automatic send_random();
    int r;
    logic op;
    logic [15:0] addr;
    logic [7:0] seq;
    logic [7:0] cmd;
    r = $urandom_range(0, 99);
    op = OP_FRAME;
    addr = pick_addr();
    seq = 8'($urandom_range(0, 255));
    cmd = 8'($urandom_range(0, 255));
    if (r < 22) begin
      op = OP_TICK;
    end else if (r < 34 || (!sess_up && r < 70)) begin
      cmd = CMD_CONNECT;
      if (sess_up && $urandom_range(0, 1) == 1) addr = holder;
    end else if (r < 82 && sess_up) begin
      addr = holder;
      case ($urandom_range(0, 7))
        0, 1: seq = last_seq;
        2: seq = 8'($urandom_range(0, 255));
        default: seq = last_seq + 8'd1;
      endcase
      if ($urandom_range(0, 7) != 0) cmd = 8'($urandom_range(CMD_CONNECT + 1, CMD_KNOWN_MAX));
    end
    send_req(op, addr, seq, cmd, 1'b0, '0);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_keepalive(input logic [7:0] value);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.keepalive_ticks <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    ka_ticks = value;
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [7:0] value, input int sender_idle,
                           input int receiver_stall, input int count);
    write_keepalive(value);
    idle_pct = sender_idle;
    stall_pct = receiver_stall;
    repeat (count) send_random();
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    hold_off <= 1'b0;
    wait (hold_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    link_result_t want;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with no request pending");
        end else begin
          want = pending_results.pop_front();
          if (out_ch.action !== want.action)
            report_mismatch($sformatf("action %0d, expected %0d", out_ch.action, want.action));
          if (out_ch.link_up !== want.link_up)
            report_mismatch($sformatf("link_up %0b, expected %0b", out_ch.link_up,
                                      want.link_up));
          if (out_ch.client_addr !== want.client_addr)
            report_mismatch($sformatf("client_addr %h, expected %h", out_ch.client_addr,
                                      want.client_addr));
        end
      end
      out_ch.ready <= !hold_off && ($urandom_range(0, 99) >= stall_pct);
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.op <= OP_FRAME;
    in_ch.src_addr <= 16'h0000;
    in_ch.seqnum <= 8'h00;
    in_ch.command <= 8'h00;
    cfg_ch.valid <= 1'b0;
    cfg_ch.keepalive_ticks <= 8'd0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NUM_ROWS; i++) begin
      if (plan[i].kind == ROW_CFG) begin
        write_keepalive(plan[i].ka);
      end else begin
        send_req(plan[i].op, plan[i].addr, plan[i].seq, plan[i].cmd, plan[i].typed,
                 '{plan[i].action, plan[i].link_up, plan[i].client_addr});
      end
    end

    run_phase(8'd3, 0, 0, 90);
    run_phase(8'd0, 73, 0, 80);
    run_phase(8'd255, 0, 73, 80);
    run_phase(8'd1, 16, 16, 80);

    // The receiver holds off while requests keep coming, so the input stalls.
    write_keepalive(KEEPALIVE_RESET);
    idle_pct = 0;
    stall_pct = 0;
    hold_go = 1'b1;
    repeat (40) send_random();

    run_phase(8'($urandom_range(1, 20)), 0, 0, 40);
    run_phase(8'($urandom_range(1, 20)), 16, 16, 80);

    drain();
    repeat (10) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> single_client_session_filter.f
rtl/scsf_pkg.sv
rtl/scsf_if.sv
rtl/single_client_session_filter.sv
tb/sv/tb.sv
